// ----- src/mse_pkg.sv -----
// Shared types, constants and the CORDIC angle table of the mode-sum evaluator.
package mse_pkg;

	localparam int MODES_DEF = 16;
	localparam int STEPS_DEF = 16;
	localparam int CFG_W     = 5;
	localparam int RESULT_W  = 52;
	localparam int CW_W      = 34;
	localparam logic signed [CW_W-1:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic [0:0] ACT_LOAD = 1'b0;
	localparam logic [0:0] ACT_EVAL = 1'b1;

	typedef struct packed {
		logic [0:0]          action;
		logic [3:0]          mode_index;
		logic signed [15:0]  coupling_re;
		logic signed [15:0]  coupling_im;
		logic signed [31:0]  frequency;
		logic signed [31:0]  lag;
	} in_item_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] corr_re;
		logic signed [RESULT_W-1:0] corr_im;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_PHASE, ST_INIT, ST_ITER, ST_ROUND, ST_ACC, ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic eval_start;
		logic phase;
		logic init;
		logic step;
		logic round;
		logic acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_eval;
		logic none;
		logic last_mode;
		logic steps_done;
		logic out_free;
	} sts_t;

	// atan(2^-k) in units of 2^-32 turn
	function automatic logic [29:0] atan_turn(input logic [4:0] k);
		logic [29:0] a;
		unique case (k)
			5'd0:  a = 30'd536870912;
			5'd1:  a = 30'd316933406;
			5'd2:  a = 30'd167458907;
			5'd3:  a = 30'd85004756;
			5'd4:  a = 30'd42667331;
			5'd5:  a = 30'd21354465;
			5'd6:  a = 30'd10679838;
			5'd7:  a = 30'd5340245;
			5'd8:  a = 30'd2670163;
			5'd9:  a = 30'd1335087;
			5'd10: a = 30'd667544;
			5'd11: a = 30'd333772;
			5'd12: a = 30'd166886;
			5'd13: a = 30'd83443;
			5'd14: a = 30'd41722;
			5'd15: a = 30'd20861;
			5'd16: a = 30'd10430;
			5'd17: a = 30'd5215;
			5'd18: a = 30'd2608;
			5'd19: a = 30'd1304;
			5'd20: a = 30'd652;
			5'd21: a = 30'd326;
			5'd22: a = 30'd163;
			5'd23: a = 30'd81;
			5'd24: a = 30'd41;
			5'd25: a = 30'd20;
			5'd26: a = 30'd10;
			5'd27: a = 30'd5;
			5'd28: a = 30'd3;
			5'd29: a = 30'd1;
			5'd30: a = 30'd1;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

// ----- src/mse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/mse_ctrl.sv -----
// Sequencer for load and evaluate items of the mode-sum evaluator.
module mse_ctrl
	import mse_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t st_q, st_nxt;
	logic accept;

	assign accept = in_valid && (st_q == ST_IDLE);

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept && sts.is_eval) begin
					st_nxt = sts.none ? ST_DONE : ST_READ;
				end
			end
			ST_READ:  st_nxt = ST_PHASE;
			ST_PHASE: st_nxt = ST_INIT;
			ST_INIT:  st_nxt = ST_ITER;
			ST_ITER: begin
				if (sts.steps_done) begin
					st_nxt = ST_ROUND;
				end
			end
			ST_ROUND: st_nxt = ST_ACC;
			ST_ACC:   st_nxt = sts.last_mode ? ST_DONE : ST_READ;
			ST_DONE: begin
				if (sts.out_free) begin
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = accept && !sts.is_eval;
				cmd.eval_start = accept && sts.is_eval;
			end
			ST_PHASE: cmd.phase = 1'b1;
			ST_INIT:  cmd.init = 1'b1;
			ST_ITER:  cmd.step = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_ACC:   cmd.acc = 1'b1;
			ST_DONE:  cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	a_load_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !sts.is_eval) |=> (st_q == ST_IDLE))
		else $error("load item did not finish in one cycle");
	a_iter_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ITER && !sts.steps_done) |=> (st_q == ST_ITER))
		else $error("rotation left early");
	a_round_after_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND) |-> ($past(st_q) == ST_ITER))
		else $error("rounding without rotation");
endmodule

// ----- src/mse_dp.sv -----
// Datapath: mode table, phase multiply, shared CORDIC rotator, accumulators, result register.
module mse_dp
	import mse_pkg::*;
#(
	parameter int MODES        = MODES_DEF,
	parameter int CORDIC_STEPS = STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             out_ready,
	output logic             out_valid,
	output out_item_t        out_data,
	input  cmd_t             cmd,
	output sts_t             sts
);
	localparam int AW = (MODES > 1) ? $clog2(MODES) : 1;
	localparam int CW = $clog2(MODES + 1);
	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	logic [CFG_W-1:0] active_q;
	logic [CW-1:0]    n_q, mode_q;
	logic [31:0]      lag_q, phase_q, w_q;
	logic [63:0]      wdata, rdata;
	logic signed [31:0] re2, im2;
	logic [31:0]      weight;
	logic             in_range;
	logic [SW-1:0]    step_q;
	logic             flip_q;
	logic signed [CW_W-1:0] x_q, y_q, z_q, dx, dy, ang;
	logic signed [15:0] c_q, s_q;
	logic signed [RESULT_W-1:0] acc_re_q, acc_im_q;
	logic             flip;
	logic [31:0]      p;
	logic signed [CW_W:0] vx, vy;
	logic signed [48:0] prod_c, prod_s;
	logic             out_valid_q;
	out_item_t        out_q;

	function automatic logic signed [15:0] to_q15(input logic signed [CW_W:0] v);
		logic signed [CW_W:0] r;
		r = (v + (CW_W+1)'(16384)) >>> 15;
		if (r > (CW_W+1)'(32767)) begin
			return 16'sd32767;
		end else if (r < -(CW_W+1)'(32768)) begin
			return -16'sd32768;
		end
		return r[15:0];
	endfunction

	assign re2      = in_data.coupling_re * in_data.coupling_re;
	assign im2      = in_data.coupling_im * in_data.coupling_im;
	assign weight   = 32'(re2) + 32'(im2);
	assign in_range = 9'(in_data.mode_index) < 9'(MODES);
	assign wdata    = {weight, in_data.frequency};

	mse_ram #(.WIDTH(64), .DEPTH(MODES)) u_table (
		.clk   (clk),
		.we    (cmd.load && in_range),
		.waddr (AW'(in_data.mode_index)),
		.wdata (wdata),
		.raddr (AW'(mode_q)),
		.rdata (rdata)
	);

	// Fold the phase into [-1/4, 1/4) turn; negate the result afterwards.
	assign flip = phase_q[31] ^ phase_q[30];
	assign p    = flip ? (phase_q ^ 32'h8000_0000) : phase_q;
	assign dx   = y_q >>> step_q;
	assign dy   = x_q >>> step_q;
	assign ang  = CW_W'({4'b0, atan_turn(5'(step_q))});
	assign vx   = flip_q ? -(CW_W+1)'(x_q) : (CW_W+1)'(x_q);
	assign vy   = flip_q ? -(CW_W+1)'(y_q) : (CW_W+1)'(y_q);
	assign prod_c = $signed({1'b0, w_q}) * c_q;
	assign prod_s = $signed({1'b0, w_q}) * s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			mode_q      <= '0;
			step_q      <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.eval_start) begin
				n_q    <= (9'(active_q) > 9'(MODES)) ? CW'(MODES) : CW'(active_q);
				mode_q <= '0;
			end else if (cmd.acc) begin
				mode_q <= mode_q + CW'(1);
			end
			if (cmd.init) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_start) begin
			lag_q    <= in_data.lag;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end
		if (cmd.phase) begin
			phase_q <= 32'(rdata[31:0] * lag_q);
			w_q     <= rdata[63:32];
		end
		if (cmd.init) begin
			flip_q <= flip;
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= CW_W'($signed(p));
		end else if (cmd.step) begin
			if (!z_q[CW_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
		if (cmd.round) begin
			c_q <= to_q15(vx);
			s_q <= to_q15(vy);
		end
		if (cmd.acc) begin
			acc_re_q <= acc_re_q + RESULT_W'(prod_c);
			acc_im_q <= acc_im_q - RESULT_W'(prod_s);
		end
		if (cmd.out_load) begin
			out_q.corr_re <= acc_re_q;
			out_q.corr_im <= acc_im_q;
		end
	end

	assign sts.is_eval    = (in_data.action == ACT_EVAL);
	assign sts.none       = (active_q == '0);
	assign sts.last_mode  = ((mode_q + CW'(1)) == n_q);
	assign sts.steps_done = (step_q == SW'(CORDIC_STEPS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && out_valid_q) |-> out_ready)
		else $error("result overwritten before it was taken");
	a_mode_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> (mode_q < n_q))
		else $error("mode counter past active count");
endmodule

// ----- src/mode_sum_correlation_evaluator_unit.sv -----
// A load item is written while the controller stays idle; an evaluate item runs the one shared
// CORDIC rotator over n = min(active_modes, MODES) modes, one after another. One item is
// worked at a time; a result waits in an output register while the next item is taken. Reset
// (arst_n low) clears the controller, the active_modes register and the result valid; the
// mode table keeps no reset contents.
module mode_sum_correlation_evaluator_unit
	import mse_pkg::*;
#(
	parameter int MODES        = MODES_DEF,
	parameter int CORDIC_STEPS = STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	mse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mse_dp #(.MODES(MODES), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

// ----- sim/mse_checker.sv -----
// Checker of the mode-sum evaluator: watches the channels, predicts each correlation sum, compares.
module mse_checker
	import mse_pkg::*;
#(
	parameter int MODES        = MODES_DEF,
	parameter int CORDIC_STEPS = STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0]      weights [MODES];
	logic [31:0]      freqs [MODES];
	logic [CFG_W-1:0] mode_count;
	out_item_t        sums_due [$];

	function automatic longint round_q15(longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	function automatic longint atan_lut(int k);
		longint t [32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return t[k];
	endfunction

	// cos and sin of a phase given in 2^-32 turns, Q1.15
	function automatic void cos_sin(logic [31:0] phase, output longint c, output longint s);
		logic        flip;
		logic [31:0] p;
		longint      x, y, z, dx, dy, a;
		flip = phase[31] ^ phase[30];
		p = flip ? phase - 32'h8000_0000 : phase;
		z = longint'(signed'(p));
		x = 652032875;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			a = longint'(atan_lut(i));
			if (z >= 0) begin
				x -= dx; y += dy; z -= a;
			end else begin
				x += dx; y -= dy; z += a;
			end
		end
		c = round_q15(flip ? -x : x);
		s = round_q15(flip ? -y : y);
	endfunction

	function automatic out_item_t correlation_at(logic [31:0] lag);
		int          n;
		longint      acc_re, acc_im, c, s, w;
		logic [63:0] prod;
		out_item_t   r;
		n = (mode_count > MODES) ? MODES : mode_count;
		acc_re = 0;
		acc_im = 0;
		for (int i = 0; i < n; i++) begin
			prod = 64'(freqs[i]) * 64'(lag);
			cos_sin(prod[31:0], c, s);
			w = longint'({32'd0, weights[i]});
			acc_re += w * c;
			acc_im -= w * s;
		end
		r.corr_re = acc_re[RESULT_W-1:0];
		r.corr_im = acc_im[RESULT_W-1:0];
		return r;
	endfunction

	assign pending = sums_due.size();

	always @(posedge clk or negedge arst_n) begin
		longint    re, im;
		out_item_t want;
		if (!arst_n) begin
			mode_count <= '0;
			errors = 0;
			sums_due.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (in_data.action == ACT_LOAD) begin
					if (in_data.mode_index < MODES) begin
						re = longint'(in_data.coupling_re);
						im = longint'(in_data.coupling_im);
						weights[in_data.mode_index] = 32'(re * re + im * im);
						freqs[in_data.mode_index] = in_data.frequency;
					end
				end else begin
					sums_due.push_back(correlation_at(in_data.lag));
				end
			end
			if (out_valid && out_ready) begin
				if (sums_due.size() == 0) begin
					$error("unexpected result re=%0d im=%0d", out_data.corr_re, out_data.corr_im);
					errors++;
				end else begin
					want = sums_due.pop_front();
					if (want.corr_re !== out_data.corr_re) begin
						$error("corr_re expected %0d actual %0d", want.corr_re, out_data.corr_re);
						errors++;
					end
					if (want.corr_im !== out_data.corr_im) begin
						$error("corr_im expected %0d actual %0d", want.corr_im, out_data.corr_im);
						errors++;
					end
				end
			end
			if (cfg_we) mode_count <= cfg_data;
		end
	end
endmodule

// ----- sim/mode_sum_correlation_evaluator_unit_tb.sv -----
// Testbench top of the mode-sum evaluator: stimulus, receiver stalls and the verdict.
module mode_sum_correlation_evaluator_unit_tb;
	import mse_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 4_000_000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_data;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	int               errors, pending;
	longint           cycles = 0;
	bit               hold_req = 0;
	int               burst_left = 0;

	mode_sum_correlation_evaluator_unit dut (.*);

	mse_checker chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stall pattern, plus one long hold-off on request
	initial begin
		int mode;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end else begin
				mode = int'((cycles / 5000) % 3);
				if (mode == 0) out_ready <= 1'b1;
				else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
				else out_ready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	task automatic send(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic load(logic [3:0] idx, logic [15:0] re, logic [15:0] im, logic [31:0] f);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
		it.action = ACT_LOAD;
		it.mode_index = idx;
		it.coupling_re = re;
		it.coupling_im = im;
		it.frequency = f;
		send(it);
	endtask

	task automatic evaluate(logic [31:0] lag);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
		it.action = ACT_EVAL;
		it.lag = lag;
		send(it);
	endtask

	// drain everything, then write the mode count
	task automatic set_modes(logic [CFG_W-1:0] n);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no active modes: empty sum
		evaluate(32'h1234_5678);
		load(4'd0, 16'h8000, 16'h8000, 32'h7FFF_FFFF);
		load(4'd15, 16'h7FFF, 16'h7FFF, 32'h8000_0000);
		load(4'd1, 16'h0000, 16'h0000, 32'h4000_0000);
		load(4'd2, 16'h8000, 16'h0000, 32'hC000_0000);
		for (int i = 3; i < 15; i++)
			load(4'(i), 16'($urandom), 16'($urandom), $urandom);
		set_modes(5'd16);
		evaluate(32'd0);
		evaluate(32'd1);
		evaluate(32'hFFFF_FFFF);
		evaluate(32'h7FFF_FFFF);
		evaluate(32'h8000_0000);
		set_modes(5'd31);
		evaluate(32'd3);
		set_modes(5'd1);
		evaluate(32'd2);
		evaluate(32'h0000_0001);

		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 11) n = 5'd0;
			else if (phase == 10) n = 5'd16;
			else n = 5'($urandom_range(0, 31));
			set_modes(n);
			if (phase == 3) hold_req = 1;
			for (int k = 0; k < 135; k++) begin
				if ($urandom_range(0, 1) == 0)
					load(4'($urandom), 16'($urandom), 16'($urandom), $urandom);
				else if ($urandom_range(0, 7) == 0)
					evaluate($urandom_range(0, 4));
				else
					evaluate($urandom);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
